@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define TRPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication under an active-low reset.
`define TRPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

@@ src/trpf_pkg.sv @@
// Package: widths, register codes and shared types of the peak finder.
`timescale 1ns / 1ps
package trpf_pkg;
	localparam int SAMPLE_W    = 16;
	localparam int POS_W       = 12;
	localparam int WSTART_W    = 12;
	localparam int WEND_W      = 13;
	localparam int FACTOR_W    = 16;
	localparam int MINW_W      = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 2;
	localparam int SHORT_TRACE = 2;
	localparam int MIN_WINDOW  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FACTOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH    = 2'd3;

	localparam logic [WSTART_W-1:0] WINDOW_START_RST = 12'd0;
	localparam logic [WEND_W-1:0]   WINDOW_END_RST   = 13'd4096;
	localparam logic [FACTOR_W-1:0] LEVEL_FACTOR_RST = 16'd32768;
	localparam logic [MINW_W-1:0]   MIN_WIDTH_RST    = 13'd1;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_res_t;
endpackage

@@ src/threshold_region_peak_finder.sv @@
// Top level: trace store, sequencer and result register of the peak finder.
// Usage:
//   Slave channel s_*: one sample per request, tlast marks the last sample of a
//   trace. Samples load at one per cycle while idle; those past TRACE_DEPTH drop.
//   Config channel cfg_*: always ready; write only while the block is idle.
//   Master channel m_*: one result per peak in the window, up to MAX_PEAKS, tlast
//   on the last one; a trace with no peak gives one result with peak_valid low.
// Sequence after the last sample, for a window clamped to the loaded trace: a
//   setup step, a min/max pass over the window on the shared comparator, a
//   multiply and an add step for the level, a threshold scan on the same
//   comparator and a step to load the result. A window too short for peaks
//   goes from setup straight to its result. The block is not ready meanwhile.
// Stall: a held result stops the scan at its next peak until m_tready rises;
//   once the final result is registered the block takes samples again.
// Reset: all control state clears, registers take their defaults and the
//   loaded count returns to zero; the trace store is not cleared.
`timescale 1ns / 1ps
module threshold_region_peak_finder import trpf_pkg::*; #(
	parameter int TRACE_DEPTH = 4096,
	parameter int MAX_PEAKS   = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] peak_position, [15:12] zero
	output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] peak_valid, [1] overflow
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	localparam int AW = $clog2(TRACE_DEPTH);
	localparam int CW = $clog2(TRACE_DEPTH + 1);
	localparam int LW = (CW > WEND_W) ? CW : WEND_W;
	localparam int PW = $clog2(MAX_PEAKS + 1);

	localparam logic [3:0] ST_LOAD    = 4'd0;
	localparam logic [3:0] ST_SETUP   = 4'd1;
	localparam logic [3:0] ST_MM_INIT = 4'd2;
	localparam logic [3:0] ST_MM_LO   = 4'd3;
	localparam logic [3:0] ST_MM_HI   = 4'd4;
	localparam logic [3:0] ST_MUL     = 4'd5;
	localparam logic [3:0] ST_LVL     = 4'd6;
	localparam logic [3:0] ST_SC_CLS  = 4'd7;
	localparam logic [3:0] ST_SC_STEP = 4'd8;
	localparam logic [3:0] ST_FIN     = 4'd9;

	logic [3:0]          state_q;
	logic [WSTART_W-1:0] window_start_q;
	logic [WEND_W-1:0]   window_end_q;
	logic [FACTOR_W-1:0] level_factor_q;
	logic [MINW_W-1:0]   min_width_q;

	logic [CW-1:0] cnt_q;
	logic [LW-1:0] last_q;
	logic          short_q;
	logic [LW-1:0] j_q;
	logic          pb_q, ca_q, cb_q, na_q, nb_q;
	logic          in_reg_q;
	logic [LW-1:0] begin_q;
	logic [PW-1:0] peaks_q;
	logic          drop_q;
	logic          pend_v_q;
	logic          out_v_q;

	logic [SAMPLE_W-1:0]   low_q, high_q, cval_q, nval_q, best_val_q, lvl_int_q;
	logic [2*SAMPLE_W-1:0] prod_q;
	logic                  lvl_frac_q;
	logic [LW-1:0]         best_idx_q;
	logic [POS_W-1:0]      pend_pos_q;
	logic [POS_W-1:0]      out_pos_q;
	logic                  out_pv_q, out_ov_q, out_last_q;

	logic                  acc, cnt_full, ram_we, rd_en;
	logic [CW-1:0]         cnt_new;
	logic [LW-1:0]         cnt_ext, last_new, first_w, rd_addr, j_nxt, i_idx, beg;
	logic [SAMPLE_W-1:0]   ram_rdata, cmp_a, cmp_b, best_op, bv;
	logic [LW-1:0]         best_i_op, bi;
	logic [LW:0]           len;
	logic [2*SAMPLE_W-1:0] lvl_sum;
	cmp_res_t              cmp;
	logic                  bad, more, cls_a, cls_b, warm;
	logic                  open, inr, upd, close, hit, keep, push, out_free, stall;
	logic                  fin_go, out_load;
	logic [POS_W-1:0]      ld_pos;
	logic                  ld_pv, ld_ov, ld_last;

	assign s_tready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign acc       = s_tvalid & s_tready;
	assign cnt_full  = (cnt_q == CW'(TRACE_DEPTH));
	assign ram_we    = acc & ~cnt_full;
	assign cnt_new   = cnt_full ? cnt_q : cnt_q + 1'b1;
	assign cnt_ext   = LW'(cnt_new);
	assign last_new  = (LW'(window_end_q) > cnt_ext) ? cnt_ext : LW'(window_end_q);
	assign first_w   = LW'(window_start_q);
	assign bad       = short_q || (first_w >= last_q) || ((last_q - first_w) < LW'(MIN_WINDOW));
	assign j_nxt     = j_q + 1'b1;
	assign more      = (j_nxt < last_q);
	assign warm      = ((j_q - first_w) < LW'(2));

	trpf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TRACE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(s_tdata[SAMPLE_W-1:0]),
		.re   (rd_en),
		.raddr(rd_addr[AW-1:0]),
		.rdata(ram_rdata)
	);

	trpf_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.res(cmp)
	);

	always_comb begin
		cmp_a = ram_rdata;
		cmp_b = '0;
		unique case (state_q)
			ST_MM_LO:   cmp_b = low_q;
			ST_MM_HI:   cmp_b = high_q;
			ST_SC_CLS:  cmp_b = lvl_int_q;
			ST_SC_STEP: begin
				cmp_a = cval_q;
				cmp_b = best_op;
			end
			default:    cmp_b = '0;
		endcase
	end

	assign cls_a = cmp.gt;
	assign cls_b = cmp.lt | (cmp.eq & lvl_frac_q);

	assign i_idx     = j_q - 1'b1;
	assign open      = ca_q & pb_q;
	assign inr       = open | in_reg_q;
	assign best_op   = open ? '0 : best_val_q;
	assign best_i_op = open ? '0 : best_idx_q;
	assign beg       = open ? i_idx : begin_q;
	assign upd       = inr & cmp.gt;
	assign bv        = upd ? cval_q : best_op;
	assign bi        = upd ? i_idx : best_i_op;
	assign close     = inr & ca_q & nb_q;
	assign len       = (LW+1)'(i_idx - beg) + 1'b1;
	assign hit       = close & (len >= (LW+1)'(min_width_q)) & (bv != '0);
	assign keep      = hit & (peaks_q != PW'(MAX_PEAKS));
	assign push      = keep & pend_v_q;
	assign out_free  = ~out_v_q | m_tready;
	assign stall     = push & ~out_free;
	assign fin_go    = (state_q == ST_FIN) & out_free;
	assign lvl_sum   = {low_q, {SAMPLE_W{1'b0}}} + prod_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = j_nxt;
		unique case (state_q)
			ST_SETUP: begin
				rd_en   = ~bad;
				rd_addr = first_w;
			end
			ST_MM_INIT: rd_en = 1'b1;
			ST_MM_HI:   rd_en = more;
			ST_LVL: begin
				rd_en   = 1'b1;
				rd_addr = first_w;
			end
			ST_SC_CLS:  rd_en = warm & more;
			ST_SC_STEP: rd_en = ~stall & more;
			default:    rd_en = 1'b0;
		endcase
	end

	always_comb begin
		out_load = 1'b0;
		ld_pos   = pend_pos_q;
		ld_pv    = 1'b1;
		ld_ov    = 1'b0;
		ld_last  = 1'b0;
		priority if ((state_q == ST_SC_STEP) && push && out_free) begin
			out_load = 1'b1;
		end else if (fin_go) begin
			out_load = 1'b1;
			ld_last  = 1'b1;
			ld_pv    = pend_v_q;
			ld_ov    = pend_v_q & drop_q;
			ld_pos   = pend_v_q ? pend_pos_q : '0;
		end else begin
			out_load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			window_start_q <= WINDOW_START_RST;
			window_end_q   <= WINDOW_END_RST;
			level_factor_q <= LEVEL_FACTOR_RST;
			min_width_q    <= MIN_WIDTH_RST;
			cnt_q          <= '0;
			last_q         <= '0;
			short_q        <= 1'b0;
			j_q            <= '0;
			{pb_q, ca_q, cb_q, na_q, nb_q} <= '0;
			in_reg_q       <= 1'b0;
			begin_q        <= '0;
			peaks_q        <= '0;
			drop_q         <= 1'b0;
			pend_v_q       <= 1'b0;
			out_v_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WINDOW_START: window_start_q <= cfg_data[WSTART_W-1:0];
					REG_WINDOW_END:   window_end_q   <= cfg_data[WEND_W-1:0];
					REG_LEVEL_FACTOR: level_factor_q <= cfg_data[FACTOR_W-1:0];
					REG_MIN_WIDTH:    min_width_q    <= cfg_data[MINW_W-1:0];
					default:          window_start_q <= window_start_q;
				endcase
			end

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (s_tlast) begin
							cnt_q    <= '0;
							last_q   <= last_new;
							short_q  <= (cnt_new <= CW'(SHORT_TRACE));
							peaks_q  <= '0;
							drop_q   <= 1'b0;
							pend_v_q <= 1'b0;
							in_reg_q <= 1'b0;
							state_q  <= ST_SETUP;
						end else begin
							cnt_q <= cnt_new;
						end
					end
				end
				ST_SETUP: begin
					j_q     <= first_w;
					state_q <= bad ? ST_FIN : ST_MM_INIT;
				end
				ST_MM_INIT: begin
					j_q     <= j_nxt;
					state_q <= ST_MM_LO;
				end
				ST_MM_LO: state_q <= ST_MM_HI;
				ST_MM_HI: begin
					if (more) begin
						j_q     <= j_nxt;
						state_q <= ST_MM_LO;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_LVL;
				ST_LVL: begin
					j_q      <= first_w;
					in_reg_q <= 1'b0;
					state_q  <= ST_SC_CLS;
				end
				ST_SC_CLS: begin
					if (warm) begin
						pb_q         <= cb_q;
						{ca_q, cb_q} <= {cls_a, cls_b};
						if (more) begin
							j_q <= j_nxt;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						{na_q, nb_q} <= {cls_a, cls_b};
						state_q      <= ST_SC_STEP;
					end
				end
				ST_SC_STEP: begin
					if (!stall) begin
						in_reg_q <= close ? 1'b0 : inr;
						begin_q  <= beg;
						if (keep) begin
							peaks_q  <= peaks_q + 1'b1;
							pend_v_q <= 1'b1;
						end
						if (hit && !keep) begin
							drop_q <= 1'b1;
						end
						pb_q         <= cb_q;
						{ca_q, cb_q} <= {na_q, nb_q};
						if (more) begin
							j_q     <= j_nxt;
							state_q <= ST_SC_CLS;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q  <= ld_pos;
			out_pv_q   <= ld_pv;
			out_ov_q   <= ld_ov;
			out_last_q <= ld_last;
		end
		unique case (state_q)
			ST_MM_INIT: begin
				low_q  <= ram_rdata;
				high_q <= ram_rdata;
			end
			ST_MM_LO: begin
				if (cmp.lt) begin
					low_q <= ram_rdata;
				end
			end
			ST_MM_HI: begin
				if (cmp.gt) begin
					high_q <= ram_rdata;
				end
			end
			ST_MUL: prod_q <= (2*SAMPLE_W)'(high_q - low_q) * (2*SAMPLE_W)'(level_factor_q);
			ST_LVL: begin
				lvl_int_q  <= lvl_sum[2*SAMPLE_W-1:SAMPLE_W];
				lvl_frac_q <= |lvl_sum[SAMPLE_W-1:0];
			end
			ST_SC_CLS: begin
				if (warm) begin
					cval_q <= ram_rdata;
				end else begin
					nval_q <= ram_rdata;
				end
			end
			ST_SC_STEP: begin
				if (!stall) begin
					best_val_q <= bv;
					best_idx_q <= bi;
					cval_q     <= nval_q;
					if (keep) begin
						pend_pos_q <= bi[POS_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_TDATA_W-POS_W)'(0), out_pos_q};
	assign m_tuser  = {out_ov_q, out_pv_q};
	assign m_tlast  = out_last_q;
endmodule

@@ src/trpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module trpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ src/trpf_cmp.sv @@
// Shared magnitude comparator used by every pass of the sequencer.
`timescale 1ns / 1ps
module trpf_cmp import trpf_pkg::*; (
	input  logic [SAMPLE_W-1:0] a,
	input  logic [SAMPLE_W-1:0] b,
	output cmp_res_t            res
);
	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
		res.gt = (a > b);
	end
endmodule

@@ src/trpf_checker.sv @@
// Port-level checker for the peak finder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trpf_checker import trpf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser,
	input logic                   m_tlast
);
	`TRPF_ASSERT_NXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`TRPF_ASSERT_IMP(a_empty_is_last, clk, arst_n, m_tvalid && !m_tuser[0], m_tlast)
	`TRPF_ASSERT_IMP(a_empty_is_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tuser[1])
	`TRPF_ASSERT_IMP(a_overflow_on_last, clk, arst_n, m_tvalid && m_tuser[1], m_tlast && m_tuser[0])
endmodule

bind threshold_region_peak_finder trpf_checker u_trpf_checker (.*);

@@ tb/tb_threshold_region_peak_finder.sv @@
// Testbench: streams sample traces into the peak finder, predicts and checks the reported peaks.
`timescale 1ns / 1ps
module tb_threshold_region_peak_finder;
	import trpf_pkg::*;

	localparam int TRACE_DEPTH = 4096;
	localparam int MAX_PEAKS   = 64;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             valid;
		logic             ovf;
		logic             last;
	} peak_report_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [SAMPLE_W-1:0] trace_mem [TRACE_DEPTH];
	int                  trace_len;
	logic [WSTART_W-1:0] win_start;
	logic [WEND_W-1:0]   win_end;
	logic [FACTOR_W-1:0] factor;
	logic [MINW_W-1:0]   min_run;
	logic [32:0]         cut_level;

	peak_report_t expected_peaks[$];
	int src_idle_pct;
	int snk_idle_pct;
	int errors;
	int traces_sent;
	int samples_sent;
	int results_checked;

	threshold_region_peak_finder #(
		.TRACE_DEPTH(TRACE_DEPTH),
		.MAX_PEAKS  (MAX_PEAKS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit over_level(int idx);
		return (33'(trace_mem[idx]) << 16) > cut_level;
	endfunction

	function automatic bit under_level(int idx);
		return (33'(trace_mem[idx]) << 16) < cut_level;
	endfunction

	function automatic void predict_peaks();
		int first, stop, i, open_at, best_at;
		logic [SAMPLE_W-1:0] lo, hi, best;
		bit in_run, dropped;
		logic [POS_W-1:0] hits[$];
		peak_report_t rep;
		first = int'(win_start);
		stop = (int'(win_end) > trace_len) ? trace_len : int'(win_end);
		in_run = 0;
		dropped = 0;
		open_at = 0;
		best_at = 0;
		best = '0;
		if (trace_len > SHORT_TRACE && first < stop && stop - first >= MIN_WINDOW) begin
			lo = trace_mem[first];
			hi = trace_mem[first];
			for (i = first; i < stop; i++) begin
				if (trace_mem[i] < lo) lo = trace_mem[i];
				if (trace_mem[i] > hi) hi = trace_mem[i];
			end
			cut_level = (33'(lo) << 16) + 33'(16'(hi - lo)) * 33'(factor);
			for (i = first + 1; i < stop - 1; i++) begin
				if (over_level(i) && under_level(i - 1)) begin
					in_run = 1;
					open_at = i;
					best = '0;
					best_at = 0;
				end
				if (in_run && trace_mem[i] > best) begin
					best = trace_mem[i];
					best_at = i;
				end
				if (in_run && over_level(i) && under_level(i + 1)) begin
					if (i - open_at + 1 >= int'(min_run) && best > 0) begin
						if (hits.size() < MAX_PEAKS)
							hits.push_back(POS_W'(best_at));
						else
							dropped = 1;
					end
					in_run = 0;
				end
			end
		end
		if (hits.size() == 0) begin
			rep = '{position: '0, valid: 1'b0, ovf: 1'b0, last: 1'b1};
			expected_peaks.push_back(rep);
		end else begin
			foreach (hits[k]) begin
				rep.position = hits[k];
				rep.valid = 1'b1;
				rep.last = (k == hits.size() - 1);
				rep.ovf = rep.last && dropped;
				expected_peaks.push_back(rep);
			end
		end
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (trace_len < TRACE_DEPTH) begin
			trace_mem[trace_len] = value;
			trace_len++;
		end
		if (last) begin
			predict_peaks();
			trace_len = 0;
			traces_sent++;
		end
	endtask

	task automatic send_trace(input logic [SAMPLE_W-1:0] wave[$]);
		foreach (wave[k])
			send_sample(wave[k], k == wave.size() - 1);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_peaks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_registers(input logic [WSTART_W-1:0] ws, input logic [WEND_W-1:0] we,
			input logic [FACTOR_W-1:0] lf, input logic [MINW_W-1:0] mw);
		logic [CFG_DATA_W-1:0] vals[4];
		logic [CFG_IDX_W-1:0] idx[4];
		wait_idle();
		vals = '{CFG_DATA_W'(ws), CFG_DATA_W'(we), CFG_DATA_W'(lf), CFG_DATA_W'(mw)};
		idx = '{REG_WINDOW_START, REG_WINDOW_END, REG_LEVEL_FACTOR, REG_MIN_WIDTH};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		win_start = ws;
		win_end = we;
		factor = lf;
		min_run = mw;
	endtask

	task automatic test_defaults();
		send_trace('{16'd0, 16'd65535, 16'd0, 16'd40000, 16'd40000, 16'd0, 16'd100});
		wait_idle();
	endtask

	task automatic test_short_traces();
		send_trace('{16'd7});
		send_trace('{16'd65535, 16'd0});
		send_trace('{16'd0, 16'd65535, 16'd0});
	endtask

	task automatic test_level_extremes();
		set_registers(12'd0, 13'd4096, 16'd0, 13'd1);
		send_trace('{16'd5, 16'd9, 16'd5, 16'd9, 16'd5});
		set_registers(12'd0, 13'd4096, 16'd65535, 13'd1);
		send_trace('{16'd0, 16'd65535, 16'd65534, 16'd65535, 16'd0});
		set_registers(12'd0, 13'd4096, 16'd32768, 13'd1);
		send_trace('{16'd0, 16'd1, 16'd2, 16'd1, 16'd2, 16'd0});
	endtask

	task automatic test_min_width();
		set_registers(12'd0, 13'd4096, 16'd32768, 13'd4096);
		send_trace('{16'd0, 16'd50000, 16'd0});
		set_registers(12'd0, 13'd4096, 16'd32768, 13'd0);
		send_trace('{16'd0, 16'd50000, 16'd0});
		set_registers(12'd0, 13'd4096, 16'd32768, 13'd3);
		send_trace('{16'd0, 16'd60000, 16'd60001, 16'd60001, 16'd0, 16'd60000, 16'd0});
	endtask

	task automatic test_window_edges();
		set_registers(12'd4095, 13'd0, 16'd32768, 13'd1);
		send_trace('{16'd0, 16'd50000, 16'd0, 16'd1});
		set_registers(12'd1, 13'd4, 16'd32768, 13'd1);
		send_trace('{16'd0, 16'd10, 16'd20, 16'd10, 16'd50000, 16'd0});
		set_registers(12'd1, 13'd3, 16'd32768, 13'd1);
		send_trace('{16'd0, 16'd10, 16'd20, 16'd10});
	endtask

	task automatic test_random_traces(input int budget);
		int sent, len, mode;
		bit high;
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] wave[$];
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(2) == 0)
				set_registers($urandom_range(9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 3)),
					$urandom_range(1) ? 13'd4096 : 13'($urandom_range(0, 30)),
					$urandom_range(4) == 0 ? ($urandom_range(1) ? 16'd0 : 16'd65535) : 16'($urandom),
					$urandom_range(9) == 0 ? 13'($urandom_range(0, 4096)) : 13'($urandom_range(0, 4)));
			else if ($urandom_range(6) == 0)
				wait_idle();
			case ($urandom_range(19))
				0, 1:    len = $urandom_range(1, 2);
				2:       len = $urandom_range(25, 60);
				default: len = $urandom_range(3, 24);
			endcase
			mode = $urandom_range(9);
			base = 16'($urandom_range(0, 1000));
			high = 0;
			wave.delete();
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(9) < 3) high = !high;
				if (mode < 6)
					wave.push_back(high ? 16'($urandom_range(30000, 65535))
						: base + 16'($urandom_range(0, 500)));
				else if (mode < 8)
					wave.push_back(16'($urandom));
				else
					wave.push_back(16'($urandom_range(0, 2)));
			end
			send_trace(wave);
			sent += len;
		end
	endtask

	always @(posedge clk) begin
		peak_report_t want;
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (expected_peaks.size() == 0) begin
				$display("%0t: unexpected result tdata=%0d tuser=%b tlast=%b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = expected_peaks.pop_front();
				if (m_tdata !== OUT_TDATA_W'(want.position)) begin
					$display("%0t: peak_position expected %0d got %0d", $time, want.position, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.valid) begin
					$display("%0t: peak_valid expected %b got %b", $time, want.valid, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.ovf) begin
					$display("%0t: overflow expected %b got %b", $time, want.ovf, m_tuser[1]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: final_result expected %b got %b", $time, want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WINDOW_START;
		cfg_data <= '0;
		trace_len = 0;
		win_start = WINDOW_START_RST;
		win_end = WINDOW_END_RST;
		factor = LEVEL_FACTOR_RST;
		min_run = MIN_WIDTH_RST;
		cut_level = '0;
		errors = 0;
		traces_sent = 0;
		samples_sent = 0;
		results_checked = 0;
		src_idle_pct = 20;
		snk_idle_pct = 47;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_short_traces();
		test_level_extremes();
		test_min_width();
		test_window_edges();
		test_random_traces(25);
		src_idle_pct = 47;
		snk_idle_pct = 20;
		test_random_traces(25);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_traces(25);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d traces (%0d samples); checked %0d results.",
			traces_sent, samples_sent, results_checked);
		$display("Covered window, level and width extremes, short traces and random traces.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/trpf_pkg.sv
src/trpf_ram.sv
src/trpf_cmp.sv
src/threshold_region_peak_finder.sv
src/trpf_checker.sv
tb/tb_threshold_region_peak_finder.sv
